// ===== src/fun_pkg.sv =====
// Shared types and constants for the face normal unit.
// No dependencies; face_unit_normal, fun_core and the testbench import this package.
package fun_pkg;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FACE  = 1'b1;

    localparam logic [15:0] Q15_MAX = 16'h7FFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CROSS,
        S_SQUARE,
        S_ROOT,
        S_DIVIDE,
        S_DONE
    } fun_state_t;

    typedef struct packed {
        logic [7:0] corner_a;
        logic [7:0] corner_b;
        logic [7:0] corner_c;
        logic       last_face;
    } fun_face_t;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               degenerate;
        logic               last_normal;
    } fun_result_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } fun_status_t;

endpackage

// ===== src/face_unit_normal.sv =====
// Top level of the face normal unit: stream ports, output register.
// Depends on fun_pkg, fun_vstore and fun_core.
//
// Computes the unit normal of a triangle held in an internal vertex store.
// A request with tuser=0 writes one vertex (index, x, y, z) and gives no
// result; it is taken whenever the unit is idle. A request with
// tuser=1 names three corners v1, v2, v3; the unit forms (v1-v2) x (v1-v3),
// takes the integer square root of its squared length and divides each
// component by it, giving Q1.15 values that round toward zero and saturate
// at +32767. A zero length gives the zero vector with tuser set on the
// result; tlast follows the request's tlast. A face is worked in these steps,
// of which a degenerate face skips the divides:
// three reads on the single store port, six cross-product and nine squaring
// multiplies on one shared multiplier, one root bit per cycle and one
// quotient bit per cycle on one shared wide adder. The unit takes no new
// request while a face is in work, but a finished result waits in the output
// register so the next request can be taken before it is drained. Reading a
// vertex slot never written gives an undefined normal; an index at or beyond
// VERTEX_COUNT reads as the origin and is dropped on a write.
module face_unit_normal
    import fun_pkg::*;
#(
    parameter int VERTEX_COUNT = 256,
    parameter int COORD_BITS   = 16,
    localparam int TDW = ((32 + 3 * COORD_BITS + 7) / 8) * 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // vertex_index, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c
    input  logic [TDW-1:0] s_axis_tdata,
    // op
    input  logic           s_axis_tuser,
    input  logic           s_axis_tlast,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // normal_x, normal_y, normal_z
    output logic [47:0]    m_axis_tdata,
    // degenerate
    output logic           m_axis_tuser,
    output logic           m_axis_tlast
);

    localparam int CB = COORD_BITS;

    fun_status_t status;
    fun_face_t   face;
    fun_result_t result;
    logic        accept;
    logic        start;
    logic        res_take;
    logic        rd_en;
    logic [7:0]  rd_index;
    logic [3*CB-1:0] rd_data;

    logic        m_valid_reg, m_valid_next;
    fun_result_t m_data_reg;

    // hold ready low while a face is in work
    assign s_axis_tready = status.idle;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign start         = accept && (s_axis_tuser == OP_FACE);

    assign face.corner_a  = s_axis_tdata[8+3*CB +: 8];
    assign face.corner_b  = s_axis_tdata[16+3*CB +: 8];
    assign face.corner_c  = s_axis_tdata[24+3*CB +: 8];
    assign face.last_face = s_axis_tlast;

    fun_vstore #(
        .DEPTH (VERTEX_COUNT),
        .CB    (CB)
    ) u_vstore (
        .clk      (clk),
        .wr_en    (accept && (s_axis_tuser == OP_WRITE)),
        .wr_index (s_axis_tdata[7:0]),
        .wr_data  (s_axis_tdata[8 +: 3*CB]),
        .rd_en    (rd_en),
        .rd_index (rd_index),
        .rd_data  (rd_data)
    );

    fun_core #(
        .CB (CB)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .face     (face),
        .status   (status),
        .res_take (res_take),
        .result   (result),
        .rd_en    (rd_en),
        .rd_index (rd_index),
        .rd_data  (rd_data)
    );

    // advance a finished result into the output register once it is free
    assign res_take = status.res_valid && (!m_valid_reg || m_axis_tready);

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (res_take)
            m_valid_next = 1'b1;
        else if (m_axis_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
            m_data_reg <= result;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_data_reg.normal_z, m_data_reg.normal_y, m_data_reg.normal_x};
    assign m_axis_tuser  = m_data_reg.degenerate;
    assign m_axis_tlast  = m_data_reg.last_normal;

`ifndef SYNTH
    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> m_axis_tvalid && status.idle)
        else $error("result handover did not load the output register");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("degenerate result with nonzero normal");

    a_face_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !s_axis_tready)
        else $error("unit still ready after taking a face");
`endif

endmodule

// ===== src/fun_vstore.sv =====
// Vertex store: one write port, one registered read port.
// Depends on nothing outside this file.
module fun_vstore #(
    parameter int DEPTH = 256,
    parameter int CB    = 16
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [7:0]      wr_index,
    input  logic [3*CB-1:0] wr_data,
    input  logic            rd_en,
    input  logic [7:0]      rd_index,
    output logic [3*CB-1:0] rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [3*CB-1:0] mem [DEPTH];
    logic [3*CB-1:0] rd_word_reg;
    logic            rd_oob_reg;
    logic [AW+7:0]   wr_wide;
    logic [AW+7:0]   rd_wide;
    logic            wr_in_range;
    logic            rd_in_range;

    assign wr_wide     = (AW+8)'(wr_index);
    assign rd_wide     = (AW+8)'(rd_index);
    assign wr_in_range = (32'(wr_index) < DEPTH);
    assign rd_in_range = (32'(rd_index) < DEPTH);

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_in_range)
        begin
            mem[wr_wide[AW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_wide[AW-1:0]];
            rd_oob_reg  <= !rd_in_range;
        end
    end

    // an index beyond the store reads as the origin
    assign rd_data = rd_oob_reg ? '0 : rd_word_reg;

endmodule

// ===== src/fun_core.sv =====
// Face normal sequencer with one shared multiplier and one shared wide adder.
// Depends on fun_pkg; reads vertices through the fun_vstore read port.
module fun_core
    import fun_pkg::*;
#(
    parameter int CB = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  fun_face_t       face,
    output fun_status_t     status,
    input  logic            res_take,
    output fun_result_t     result,
    output logic            rd_en,
    output logic [7:0]      rd_index,
    input  logic [3*CB-1:0] rd_data
);

    localparam int DW   = CB + 1;
    localparam int MW   = CB + 2;
    localparam int PW   = 2 * MW;
    localparam int CW   = 2 * CB + 2;
    localparam int H    = CB + 1;
    localparam int SW   = 4 * CB + 4;
    localparam int RB   = 2 * CB + 2;
    localparam int RW   = RB + 3;
    localparam int AWD  = SW + 1;
    localparam int CNTW = $clog2(RB + 1);

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_SUB  = 2'd1;
    localparam logic [1:0] KIND_HH   = 2'd0;
    localparam logic [1:0] KIND_HL   = 2'd1;
    localparam logic [1:0] KIND_LL   = 2'd2;

    fun_state_t state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [1:0]      comp_reg, comp_next;
    fun_face_t       face_reg, face_next;

    logic signed [CB-1:0] v1_reg [3];
    logic signed [DW-1:0] a_reg [3];
    logic signed [DW-1:0] b_reg [3];
    logic signed [CB-1:0] rd_coord [3];

    logic signed [PW-1:0] prod_reg;
    logic [1:0]           prod_comp_reg;
    logic [1:0]           prod_kind_reg;
    logic signed [CW-1:0] c_reg [3];
    logic [SW-1:0]        sum_reg, sum_next;
    logic [RW-1:0]        rem_reg, rem_next;
    logic [RB-1:0]        root_reg, root_next;
    logic [RB:0]          div_reg, div_next;
    logic [15:0]          q_reg, q_next;
    logic [15:0]          n_reg [3];
    logic                 degen_reg, degen_next;

    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] product;
    logic [1:0]           sel_comp, sel_kind;
    logic [1:0]           csel;
    logic signed [CW-1:0] c_sel;
    logic [CW-1:0]        mag_sel;
    logic [H-1:0]         mag_hi, mag_lo;

    logic [AWD-1:0] alu_a, alu_b, alu_res;
    logic           alu_sub;
    logic           no_borrow;
    logic [AWD-1:0] sq_addend;
    logic [RW-1:0]  rem_shift;
    logic [RB:0]    div_kept;
    logic [15:0]    q_final;
    logic [15:0]    n_sat;

    assign rd_coord[0] = signed'(rd_data[CB-1:0]);
    assign rd_coord[1] = signed'(rd_data[2*CB-1:CB]);
    assign rd_coord[2] = signed'(rd_data[3*CB-1:2*CB]);

    // product schedule: which component and which kind of term
    always_comb
    begin
        sel_comp = 2'd0;
        sel_kind = KIND_LOAD;
        if (state_reg == S_CROSS)
        begin
            case (cnt_reg)
                CNTW'(0): begin sel_comp = 2'd0; sel_kind = KIND_LOAD; end
                CNTW'(1): begin sel_comp = 2'd0; sel_kind = KIND_SUB;  end
                CNTW'(2): begin sel_comp = 2'd1; sel_kind = KIND_LOAD; end
                CNTW'(3): begin sel_comp = 2'd1; sel_kind = KIND_SUB;  end
                CNTW'(4): begin sel_comp = 2'd2; sel_kind = KIND_LOAD; end
                CNTW'(5): begin sel_comp = 2'd2; sel_kind = KIND_SUB;  end
                default:  begin sel_comp = 2'd0; sel_kind = KIND_LOAD; end
            endcase
        end
        else
        begin
            case (cnt_reg)
                CNTW'(0): begin sel_comp = 2'd0; sel_kind = KIND_HH; end
                CNTW'(1): begin sel_comp = 2'd0; sel_kind = KIND_HL; end
                CNTW'(2): begin sel_comp = 2'd0; sel_kind = KIND_LL; end
                CNTW'(3): begin sel_comp = 2'd1; sel_kind = KIND_HH; end
                CNTW'(4): begin sel_comp = 2'd1; sel_kind = KIND_HL; end
                CNTW'(5): begin sel_comp = 2'd1; sel_kind = KIND_LL; end
                CNTW'(6): begin sel_comp = 2'd2; sel_kind = KIND_HH; end
                CNTW'(7): begin sel_comp = 2'd2; sel_kind = KIND_HL; end
                CNTW'(8): begin sel_comp = 2'd2; sel_kind = KIND_LL; end
                default:  begin sel_comp = 2'd0; sel_kind = KIND_HH; end
            endcase
        end
    end

    always_comb
    begin
        if (state_reg == S_CROSS)
            csel = prod_comp_reg;
        else if (state_reg == S_SQUARE)
            csel = sel_comp;
        else
            csel = comp_reg;
    end

    assign c_sel   = c_reg[csel];
    assign mag_sel = c_sel[CW-1] ? CW'(-c_sel) : CW'(c_sel);
    assign mag_hi  = mag_sel[CW-1:H];
    assign mag_lo  = mag_sel[H-1:0];

    // shared multiplier operands
    always_comb
    begin
        mul_a = MW'(a_reg[0]);
        mul_b = MW'(b_reg[0]);
        if (state_reg == S_CROSS)
        begin
            case (cnt_reg)
                CNTW'(0): begin mul_a = MW'(a_reg[1]); mul_b = MW'(b_reg[2]); end
                CNTW'(1): begin mul_a = MW'(a_reg[2]); mul_b = MW'(b_reg[1]); end
                CNTW'(2): begin mul_a = MW'(a_reg[2]); mul_b = MW'(b_reg[0]); end
                CNTW'(3): begin mul_a = MW'(a_reg[0]); mul_b = MW'(b_reg[2]); end
                CNTW'(4): begin mul_a = MW'(a_reg[0]); mul_b = MW'(b_reg[1]); end
                CNTW'(5): begin mul_a = MW'(a_reg[1]); mul_b = MW'(b_reg[0]); end
                default:  begin mul_a = MW'(a_reg[0]); mul_b = MW'(b_reg[0]); end
            endcase
        end
        else
        begin
            case (sel_kind)
                KIND_HH: begin mul_a = $signed({1'b0, mag_hi}); mul_b = $signed({1'b0, mag_hi}); end
                KIND_HL: begin mul_a = $signed({1'b0, mag_hi}); mul_b = $signed({1'b0, mag_lo}); end
                default: begin mul_a = $signed({1'b0, mag_lo}); mul_b = $signed({1'b0, mag_lo}); end
            endcase
        end
    end

    assign product = mul_a * mul_b;

    // shared wide add/subtract
    assign rem_shift = {rem_reg[RW-3:0], sum_reg[SW-1:SW-2]};

    always_comb
    begin
        case (prod_kind_reg)
            KIND_HH: sq_addend = AWD'(prod_reg[2*H-1:0]) << (2 * H);
            KIND_HL: sq_addend = AWD'(prod_reg[2*H-1:0]) << (H + 1);
            default: sq_addend = AWD'(prod_reg[2*H-1:0]);
        endcase
    end

    always_comb
    begin
        alu_a   = AWD'(c_sel);
        alu_b   = AWD'(prod_reg);
        alu_sub = 1'b1;
        unique case (state_reg)
            S_SQUARE:
            begin
                alu_a   = AWD'(sum_reg);
                alu_b   = sq_addend;
                alu_sub = 1'b0;
            end
            S_ROOT:
            begin
                alu_a = AWD'(rem_shift);
                alu_b = AWD'({root_reg, 2'b01});
            end
            S_DIVIDE:
            begin
                alu_a = AWD'(div_reg);
                alu_b = AWD'(root_reg);
            end
            default:
            begin
                alu_a = AWD'(c_sel);
                alu_b = AWD'(prod_reg);
            end
        endcase
    end

    assign alu_res   = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign no_borrow = !alu_res[AWD-1];

    assign div_kept = no_borrow ? alu_res[RB:0] : div_reg;
    assign q_final  = {q_reg[14:0], no_borrow};
    assign n_sat    = c_sel[CW-1] ? 16'(16'd0 - q_final)
                    : (q_final[15] ? Q15_MAX : q_final);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + CNTW'(1);
        comp_next  = comp_reg;
        face_next  = face_reg;
        sum_next   = sum_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        div_next   = div_reg;
        q_next     = q_reg;
        degen_next = degen_reg;
        rd_en      = 1'b0;
        rd_index   = face_reg.corner_a;
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (start)
                begin
                    face_next  = face;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                rd_en = (cnt_reg < CNTW'(3));
                case (cnt_reg)
                    CNTW'(1): rd_index = face_reg.corner_b;
                    CNTW'(2): rd_index = face_reg.corner_c;
                    default:  rd_index = face_reg.corner_a;
                endcase
                if (cnt_reg == CNTW'(3))
                begin
                    cnt_next   = '0;
                    state_next = S_CROSS;
                end
            end
            S_CROSS:
            begin
                if (cnt_reg == CNTW'(6))
                begin
                    cnt_next   = '0;
                    sum_next   = '0;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                if (cnt_reg != CNTW'(0))
                    sum_next = alu_res[SW-1:0];
                if (cnt_reg == CNTW'(9))
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    root_next  = '0;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                sum_next  = {sum_reg[SW-3:0], 2'b00};
                rem_next  = no_borrow ? alu_res[RW-1:0] : rem_shift;
                root_next = {root_reg[RB-2:0], no_borrow};
                if (cnt_reg == CNTW'(RB - 1))
                begin
                    cnt_next   = '0;
                    comp_next  = 2'd0;
                    degen_next = (root_next == '0);
                    state_next = (root_next == '0) ? S_DONE : S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                if (cnt_reg == CNTW'(0))
                begin
                    div_next = {1'b0, mag_sel};
                    q_next   = '0;
                end
                else
                begin
                    div_next = {div_kept[RB-1:0], 1'b0};
                    q_next   = q_final;
                end
                if (cnt_reg == CNTW'(16))
                begin
                    cnt_next = '0;
                    if (comp_reg == 2'd2)
                        state_next = S_DONE;
                    else
                        comp_next = comp_reg + 2'd1;
                end
            end
            S_DONE:
            begin
                cnt_next = '0;
                if (res_take)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        face_reg      <= face_next;
        sum_reg       <= sum_next;
        rem_reg       <= rem_next;
        root_reg      <= root_next;
        div_reg       <= div_next;
        q_reg         <= q_next;
        degen_reg     <= degen_next;
        prod_reg      <= product;
        prod_comp_reg <= sel_comp;
        prod_kind_reg <= sel_kind;
        if (state_reg == S_READ)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (cnt_reg == CNTW'(1))
                    v1_reg[i] <= rd_coord[i];
                if (cnt_reg == CNTW'(2))
                    a_reg[i] <= DW'(v1_reg[i]) - DW'(rd_coord[i]);
                if (cnt_reg == CNTW'(3))
                    b_reg[i] <= DW'(v1_reg[i]) - DW'(rd_coord[i]);
            end
        end
        if (state_reg == S_CROSS && cnt_reg != CNTW'(0))
        begin
            if (prod_kind_reg == KIND_LOAD)
                c_reg[prod_comp_reg] <= CW'(prod_reg);
            else
                c_reg[prod_comp_reg] <= alu_res[CW-1:0];
        end
        if (state_reg == S_ROOT && root_next == '0 && cnt_reg == CNTW'(RB - 1))
        begin
            for (int i = 0; i < 3; i++)
                n_reg[i] <= '0;
        end
        if (state_reg == S_DIVIDE && cnt_reg == CNTW'(16))
            n_reg[comp_reg] <= n_sat;
    end

    assign status.idle      = (state_reg == S_IDLE);
    assign status.res_valid = (state_reg == S_DONE);

    assign result.normal_x    = signed'(n_reg[0]);
    assign result.normal_y    = signed'(n_reg[1]);
    assign result.normal_z    = signed'(n_reg[2]);
    assign result.degenerate  = degen_reg;
    assign result.last_normal = face_reg.last_face;

endmodule

// ===== test/face_unit_normal_tb.sv =====
// Self-checking testbench for face_unit_normal: vertex writes and face requests
// are streamed in, and every normal is checked against a local fixed-point model.
// Depends on fun_pkg and the face_unit_normal RTL.
module face_unit_normal_tb;
    import fun_pkg::*;

    localparam int DW = 80;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    // vertex_index, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c
    logic [DW-1:0] s_axis_tdata = '0;
    // op
    logic          s_axis_tuser = 1'b0;
    logic          s_axis_tlast = 1'b0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    // normal_x, normal_y, normal_z
    logic [47:0]   m_axis_tdata;
    // degenerate
    logic          m_axis_tuser;
    logic          m_axis_tlast;

    face_unit_normal uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Local copy of the vertex store; only written slots are ever named by a face.
    logic signed [15:0] mesh_x [256];
    logic signed [15:0] mesh_y [256];
    logic signed [15:0] mesh_z [256];
    bit                 slot_written [256];
    int                 written_slots [$];

    fun_result_t pending_normals [$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_cycles = 0;

    // Convert one cross-product component to Q1.15 against the root magnitude.
    function automatic logic [15:0] unit_component(longint comp, longint unsigned mag_root);
        longint unsigned mag;
        longint unsigned q;
        begin
            mag = (comp < 0) ? longint'(-comp) : longint'(comp);
            q = (mag << 15) / mag_root;
            if (comp < 0)
            begin
                if (q > 64'd32768)
                    q = 64'd32768;
                unit_component = 16'(-q);
            end
            else
            begin
                if (q > 64'd32767)
                    q = 64'd32767;
                unit_component = q[15:0];
            end
        end
    endfunction

    function automatic fun_result_t face_normal(int ia, int ib, int ic, logic last);
        longint      ax, ay, az, bx, by, bz, cx, cy, cz;
        logic [127:0] sum_sq;
        logic [127:0] trial_sq;
        logic [63:0]  root;
        logic [63:0]  trial;
        fun_result_t  r;
        begin
            ax = longint'(mesh_x[ia]) - longint'(mesh_x[ib]);
            ay = longint'(mesh_y[ia]) - longint'(mesh_y[ib]);
            az = longint'(mesh_z[ia]) - longint'(mesh_z[ib]);
            bx = longint'(mesh_x[ia]) - longint'(mesh_x[ic]);
            by = longint'(mesh_y[ia]) - longint'(mesh_y[ic]);
            bz = longint'(mesh_z[ia]) - longint'(mesh_z[ic]);
            cx = ay * bz - az * by;
            cy = az * bx - ax * bz;
            cz = ax * by - ay * bx;
            // Squares reach past 64 bits, so widen before multiplying.
            sum_sq = 128'(cx) * 128'(cx) + 128'(cy) * 128'(cy) + 128'(cz) * 128'(cz);
            // Bitwise integer square root, one bit per step from the top.
            root = '0;
            for (int bitpos = 55; bitpos >= 0; bitpos--)
            begin
                trial = root | (64'd1 << bitpos);
                trial_sq = {64'd0, trial} * {64'd0, trial};
                if (trial_sq <= sum_sq)
                    root = trial;
            end
            if (root == 0)
            begin
                r.normal_x = '0;
                r.normal_y = '0;
                r.normal_z = '0;
                r.degenerate = 1'b1;
            end
            else
            begin
                r.normal_x = unit_component(cx, root);
                r.normal_y = unit_component(cy, root);
                r.normal_z = unit_component(cz, root);
                r.degenerate = 1'b0;
            end
            r.last_normal = last;
            face_normal = r;
        end
    endfunction

    // Send one request: idle gaps first, then hold it until the unit takes it.
    task automatic send_request(logic op, logic [7:0] idx, logic [15:0] px, logic [15:0] py,
                                logic [15:0] pz, logic [7:0] ca, logic [7:0] cb,
                                logic [7:0] cc, logic last);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                @(negedge clk);
                s_axis_tvalid = 1'b0;
            end
            @(negedge clk);
            s_axis_tvalid = 1'b1;
            s_axis_tuser  = op;
            s_axis_tlast  = last;
            s_axis_tdata  = {cc, cb, ca, pz, py, px, idx};
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            // Accepted: advance the local model.
            if (op == OP_WRITE)
            begin
                mesh_x[idx] = px;
                mesh_y[idx] = py;
                mesh_z[idx] = pz;
                if (!slot_written[idx])
                begin
                    slot_written[idx] = 1'b1;
                    written_slots.push_back(idx);
                end
            end
            else
                pending_normals.push_back(face_normal(ca, cb, cc, last));
        end
    endtask

    task automatic write_vertex(logic [7:0] idx, logic [15:0] px, logic [15:0] py,
                                logic [15:0] pz);
        send_request(OP_WRITE, idx, px, py, pz, 8'($urandom), 8'($urandom), 8'($urandom),
                     1'($urandom));
    endtask

    task automatic send_face(logic [7:0] ca, logic [7:0] cb, logic [7:0] cc, logic last);
        send_request(OP_FACE, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     ca, cb, cc, last);
    endtask

    function automatic logic [7:0] any_written();
        any_written = 8'(written_slots[$urandom_range(written_slots.size() - 1)]);
    endfunction

    task automatic wait_drained();
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            wait (pending_normals.size() == 0);
            repeat (150) @(posedge clk);
        end
    endtask

    // Directed corners: extreme coordinates, extreme slots, axis-aligned and
    // degenerate faces, positive and negative saturation.
    task automatic test_directed();
        begin
            write_vertex(8'd0,   16'sd0,      16'sd0,      16'sd0);
            write_vertex(8'd1,   16'sd1,      16'sd0,      16'sd0);
            write_vertex(8'd2,   16'sd0,      16'sd1,      16'sd0);
            write_vertex(8'd255, 16'h7FFF,    16'h8000,    16'h7FFF);
            write_vertex(8'd128, 16'h8000,    16'h7FFF,    16'h8000);
            write_vertex(8'd127, 16'hFFFF,    16'h8000,    16'h0001);
            send_face(8'd0, 8'd1, 8'd2, 1'b0);      // +z exactly, saturates high
            send_face(8'd0, 8'd2, 8'd1, 1'b1);      // -z exactly, full negative
            send_face(8'd0, 8'd0, 8'd1, 1'b0);      // repeated corner: degenerate
            send_face(8'd1, 8'd1, 8'd1, 1'b1);      // all one point
            send_face(8'd255, 8'd128, 8'd127, 1'b0);
            send_face(8'd128, 8'd255, 8'd0, 1'b1);
            send_face(8'd127, 8'd0, 8'd255, 1'b0);
            write_vertex(8'd3,   16'sd2,      16'sd0,      16'sd0);
            send_face(8'd0, 8'd1, 8'd3, 1'b1);      // collinear: degenerate
            write_vertex(8'd4,   16'h7FFF,    16'h7FFF,    16'h7FFF);
            write_vertex(8'd5,   16'h8000,    16'h8000,    16'h8000);
            send_face(8'd4, 8'd5, 8'd128, 1'b0);
            send_face(8'd5, 8'd4, 8'd255, 1'b1);
            wait_drained();
        end
    endtask

    // Hold the receiver off for a long stretch while faces keep coming.
    task automatic test_backpressure();
        begin
            hold_cycles = 600;
            for (int n = 0; n < 6; n++)
                send_face(any_written(), any_written(), any_written(), 1'($urandom));
            wait_drained();
        end
    endtask

    task automatic test_random(int count, int sender_pct, int receiver_pct);
        int          pick;
        logic [7:0]  ca;
        begin
            send_idle_pct = sender_pct;
            recv_idle_pct = receiver_pct;
            for (int n = 0; n < count; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 30)
                begin
                    // Small coordinates now and then keep the magnitudes varied.
                    if ($urandom_range(3) == 0)
                        write_vertex(8'($urandom), 16'($signed($urandom_range(15)) - 8),
                                     16'($signed($urandom_range(15)) - 8),
                                     16'($signed($urandom_range(15)) - 8));
                    else
                        write_vertex(8'($urandom), 16'($urandom), 16'($urandom),
                                     16'($urandom));
                end
                else if (pick < 36)
                begin
                    ca = any_written();
                    send_face(ca, ca, any_written(), 1'($urandom));
                end
                else
                    send_face(any_written(), any_written(), any_written(), 1'($urandom));
            end
            wait_drained();
        end
    endtask

    // Receiver ready: random idling, or a counted hold-off.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each drained normal with the oldest expectation.
    always @(posedge clk)
    begin
        fun_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_normals.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected normal %h user %b last %b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                want = pending_normals.pop_front();
                if (m_axis_tdata[15:0] !== want.normal_x
                    || m_axis_tdata[31:16] !== want.normal_y
                    || m_axis_tdata[47:32] !== want.normal_z
                    || m_axis_tuser !== want.degenerate || m_axis_tlast !== want.last_normal)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"normal mismatch: expected %h %h %h deg %b last %b,",
                                  " got %h %h %h deg %b last %b"},
                                 want.normal_x, want.normal_y, want.normal_z, want.degenerate,
                                 want.last_normal, m_axis_tdata[15:0], m_axis_tdata[31:16],
                                 m_axis_tdata[47:32], m_axis_tuser, m_axis_tlast);
                end
            end
        end
    end

    initial
    begin
        #20000000;
        $display("FAIL face_unit_normal");
        $finish;
    end

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);
        test_directed();
        test_backpressure();
        test_random(250, 27, 81);
        test_random(250, 81, 27);
        test_random(250, 0, 0);
        if (mismatches == 0 && pending_normals.size() == 0)
            $display("PASS face_unit_normal");
        else
            $display("FAIL face_unit_normal");
        $finish;
    end

endmodule
